@@ design/pif_pkg.sv @@
package pif_pkg;

    // time step used when the register holds zero (about 0.05 s)
    localparam logic [15:0] DEFAULT_STEP  = 16'd3277;
    localparam int          TICKS_PER_SEC = 20;
    localparam logic [23:0] AGE_MAX       = 24'hFF_FFFF;
    localparam logic [16:0] ONE_Q16       = 17'd65536;

    // alpha divider: numerator 2*a*rem + limit, denominator 2*limit
    localparam int NUM_W = 34;
    localparam int DEN_W = 25;
    localparam int Q_W   = 8;

endpackage

@@ design/pif_div.sv @@
module pif_div
    import pif_pkg::*;
(
    input  logic                 i_clk,
    input  logic [Q_W-1:0]       i_ld,
    input  logic [NUM_W-1:0]     i_num,
    input  logic [DEN_W-1:0]     i_den,
    output logic [Q_W-1:0]       o_quo
);

    // restoring division, one quotient bit per stage, MSB first
    logic [NUM_W-1:0] r_rem [Q_W];
    logic [DEN_W-1:0] r_den [Q_W];
    logic [Q_W-1:0]   r_quo [Q_W];

    logic [NUM_W-1:0] n_rem [Q_W];
    logic [Q_W-1:0]   n_quo [Q_W];

    always_comb begin
        for (int j = 0; j < Q_W; j++) begin
            logic [NUM_W-1:0] rem_in;
            logic [DEN_W-1:0] den_in;
            logic [Q_W-1:0]   quo_in;
            logic [NUM_W-1:0] shd;
            rem_in = (j == 0) ? i_num : r_rem[(j == 0) ? 0 : j - 1];
            den_in = (j == 0) ? i_den : r_den[(j == 0) ? 0 : j - 1];
            quo_in = (j == 0) ? '0    : r_quo[(j == 0) ? 0 : j - 1];
            shd    = NUM_W'(den_in) << (Q_W - 1 - j);
            n_quo[j] = quo_in;
            if (rem_in >= shd) begin
                n_rem[j] = rem_in - shd;
                n_quo[j][Q_W-1-j] = 1'b1;
            end else begin
                n_rem[j] = rem_in;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < Q_W; j++) begin
            if (i_ld[j]) begin
                r_rem[j] <= n_rem[j];
                r_den[j] <= (j == 0) ? i_den : r_den[(j == 0) ? 0 : j - 1];
                r_quo[j] <= n_quo[j];
            end
        end
    end

    assign o_quo = r_quo[Q_W-1];

endmodule

@@ design/particle_integrate_and_fade.sv @@
// Channel   Direction  Handshake                  Payload
// input     in         i_in_valid / o_in_ready    i_pos_*, i_vel_*, i_age_in, ...
// result    out        o_out_valid / i_out_ready  o_alive, o_new_*, o_render_color, ...
// config    in         i_cfg_valid / o_cfg_ready  i_cfg_time_step
//
// Twelve-stage pipeline, one particle per cycle while the result channel is not stalled.
// The depth is set by the alpha fade divider, one quotient bit per stage.
// Synchronous active-low reset clears the stage valid bits and loads the
// default time step. A stalled stage holds; empty stages further up still fill.
module particle_integrate_and_fade
    import pif_pkg::*;
#(
    parameter int POS_WIDTH = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [15:0]                 i_cfg_time_step,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic signed [POS_WIDTH-1:0] i_pos_x,
    input  logic signed [POS_WIDTH-1:0] i_pos_y,
    input  logic signed [POS_WIDTH-1:0] i_pos_z,
    input  logic signed [POS_WIDTH-1:0] i_vel_x,
    input  logic signed [POS_WIDTH-1:0] i_vel_y,
    input  logic signed [POS_WIDTH-1:0] i_vel_z,
    input  logic [23:0]                 i_age_in,
    input  logic [15:0]                 i_lifetime,
    input  logic signed [23:0]          i_gravity,
    input  logic [23:0]                 i_drag,
    input  logic [31:0]                 i_color_in,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic                        o_alive,
    output logic signed [POS_WIDTH-1:0] o_new_pos_x,
    output logic signed [POS_WIDTH-1:0] o_new_pos_y,
    output logic signed [POS_WIDTH-1:0] o_new_pos_z,
    output logic signed [POS_WIDTH-1:0] o_new_vel_x,
    output logic signed [POS_WIDTH-1:0] o_new_vel_y,
    output logic signed [POS_WIDTH-1:0] o_new_vel_z,
    output logic [23:0]                 o_new_age,
    output logic [31:0]                 o_render_color,
    output logic                        o_visible
);

    localparam int P    = POS_WIDTH;
    localparam int NST  = 12;
    localparam int PPW  = P + 17;   // velocity times step
    localparam int VPW  = P + 18;   // velocity times drag factor
    localparam int DIV0 = 5;        // stage of the first divider step

    typedef struct packed {
        logic                  alive;
        logic [2:0][P-1:0]     pos;
        logic [2:0][P-1:0]     vel;
        logic [23:0]           age;
        logic [31:0]           color;
    } t_res;

    // saturate a two-bit-wider signed sum to P bits
    function automatic logic [P-1:0] sat(input logic [P+1:0] v);
        logic [P-1:0] r;
        if (v[P+1:P-1] == 3'b000 || v[P+1:P-1] == 3'b111)
            r = v[P-1:0];
        else if (v[P+1])
            r = {1'b1, {(P-1){1'b0}}};
        else
            r = {1'b0, {(P-1){1'b1}}};
        return r;
    endfunction

    // configuration register
    logic [15:0] r_time_step;
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_time_step <= DEFAULT_STEP;
        else if (i_cfg_valid)
            r_time_step <= i_cfg_time_step;
    end

    // stage valids and load enables, each stage fills when empty or draining
    logic [NST:1]   r_v;
    logic [NST+1:1] ld;
    always_comb begin
        ld[NST+1] = i_out_ready;
        for (int s = NST; s >= 1; s--)
            ld[s] = !r_v[s] || ld[s+1];
    end
    assign o_in_ready = ld[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int s = 1; s <= NST; s++)
                if (ld[s]) r_v[s] <= (s == 1) ? i_in_valid : r_v[(s == 1) ? 1 : s - 1];
        end
    end

    // stage 1: capture request and resolve step
    logic [2:0][P-1:0] r1_pos, r1_vel;
    logic [23:0]       r1_age, r1_drag;
    logic [15:0]       r1_life, r1_dt;
    logic [23:0]       r1_grav;
    logic [31:0]       r1_color;
    always_ff @(posedge i_clk) begin
        if (ld[1]) begin
            r1_pos   <= {i_pos_z, i_pos_y, i_pos_x};
            r1_vel   <= {i_vel_z, i_vel_y, i_vel_x};
            r1_age   <= i_age_in;
            r1_life  <= i_lifetime;
            r1_grav  <= i_gravity;
            r1_drag  <= i_drag;
            r1_color <= i_color_in;
            r1_dt    <= (r_time_step == '0) ? DEFAULT_STEP : r_time_step;
        end
    end

    // stage 2: ageing, gravity and drag products
    logic [2:0][P-1:0] r2_pos, r2_vel;
    logic [23:0]       r2_age, r2_limit;
    logic              r2_alive;
    logic [15:0]       r2_dt;
    logic [31:0]       r2_color;
    logic [40:0]       r2_gdt;
    logic [39:0]       r2_ddt;
    logic [20:0]       n2_tick;
    logic [24:0]       n2_sum;
    logic [23:0]       n2_age, n2_limit;
    always_comb begin
        n2_tick  = (21'(r1_dt) * 21'(TICKS_PER_SEC) + 21'd128) >> 8;
        n2_sum   = 25'(r1_age) + 25'(n2_tick);
        n2_age   = n2_sum[24] ? AGE_MAX : n2_sum[23:0];
        n2_limit = {r1_life, 8'd0};
    end
    always_ff @(posedge i_clk) begin
        if (ld[2]) begin
            r2_pos   <= r1_pos;
            r2_vel   <= r1_vel;
            r2_age   <= n2_age;
            r2_limit <= n2_limit;
            r2_alive <= n2_age < n2_limit;
            r2_dt    <= r1_dt;
            r2_color <= r1_color;
            r2_gdt   <= 41'($signed(r1_grav) * $signed({1'b0, r1_dt}));
            r2_ddt   <= 40'(r1_drag) * 40'(r1_dt);
        end
    end

    // stage 3: vertical velocity, drag factor, alpha product
    logic [2:0][P-1:0] r3_pos, r3_vel;
    logic [23:0]       r3_age, r3_limit;
    logic              r3_alive;
    logic [15:0]       r3_dt;
    logic [31:0]       r3_color;
    logic [16:0]       r3_factor;
    logic [31:0]       r3_arem;
    logic [40:0]       n3_gr;
    logic [39:0]       n3_dr;
    logic [23:0]       n3_pd;
    logic [P+1:0]      n3_vy;
    always_comb begin
        n3_gr = 41'($signed(r2_gdt) + 41'sd32768);
        n3_vy = (P+2)'($signed(r2_vel[1])) + (P+2)'($signed(n3_gr[40:16]));
        n3_dr = r2_ddt + 40'd32768;
        n3_pd = n3_dr[39:16];
    end
    always_ff @(posedge i_clk) begin
        if (ld[3]) begin
            r3_pos    <= r2_pos;
            r3_vel    <= {r2_vel[2], sat(n3_vy), r2_vel[0]};
            r3_age    <= r2_age;
            r3_limit  <= r2_limit;
            r3_alive  <= r2_alive;
            r3_dt     <= r2_dt;
            r3_color  <= r2_color;
            r3_factor <= (n3_pd >= 24'(ONE_Q16)) ? '0 : ONE_Q16 - n3_pd[16:0];
            r3_arem   <= 32'(r2_color[31:24]) * 32'(r2_limit - r2_age);
        end
    end

    // stage 4: position products, divider operands
    logic [2:0][P-1:0]   r4_pos, r4_vel;
    logic [2:0][PPW-1:0] r4_pp;
    logic [23:0]         r4_age;
    logic                r4_alive;
    logic [31:0]         r4_color;
    logic [16:0]         r4_factor;
    logic [NUM_W-1:0]    r4_num;
    logic [DEN_W-1:0]    r4_den;
    always_ff @(posedge i_clk) begin
        if (ld[4]) begin
            r4_pos    <= r3_pos;
            r4_vel    <= r3_vel;
            for (int i = 0; i < 3; i++)
                r4_pp[i] <= PPW'($signed(r3_vel[i]) * $signed({1'b0, r3_dt}));
            r4_age    <= r3_age;
            r4_alive  <= r3_alive;
            r4_color  <= r3_color;
            r4_factor <= r3_factor;
            r4_num    <= NUM_W'({r3_arem, 1'b0}) + NUM_W'(r3_limit);
            r4_den    <= {r3_limit, 1'b0};
        end
    end

    // stage 5: new positions, drag products
    logic [2:0][P-1:0]   r5_pos;
    logic [2:0][VPW-1:0] r5_vp;
    logic [23:0]         r5_age;
    logic                r5_alive;
    logic [31:0]         r5_color;
    logic [2:0][P-1:0]   n5_pos;
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            logic [PPW-1:0] rp;
            rp = PPW'($signed(r4_pp[i]) + $signed(PPW'(32768)));
            n5_pos[i] = sat((P+2)'($signed(r4_pos[i])) + (P+2)'($signed(rp[PPW-1:16])));
        end
    end
    always_ff @(posedge i_clk) begin
        if (ld[5]) begin
            r5_pos   <= n5_pos;
            for (int i = 0; i < 3; i++)
                r5_vp[i] <= VPW'($signed(r4_vel[i]) * $signed({1'b0, r4_factor}));
            r5_age   <= r4_age;
            r5_alive <= r4_alive;
            r5_color <= r4_color;
        end
    end

    // stage 6: dragged velocities, dead records cleared
    t_res r_res [6:NST];
    t_res n6_res;
    always_comb begin
        n6_res.alive = r5_alive;
        n6_res.pos   = r5_pos;
        n6_res.age   = r5_age;
        n6_res.color = r5_color;
        for (int i = 0; i < 3; i++) begin
            logic [VPW-1:0] rv;
            rv = VPW'($signed(r5_vp[i]) + $signed(VPW'(32768)));
            n6_res.vel[i] = sat(rv[VPW-1:16]);
        end
        if (!r5_alive)
            n6_res = '0;
    end

    // stages 6 to 12: results wait for the alpha divider
    always_ff @(posedge i_clk) begin
        for (int s = 6; s <= NST; s++)
            if (ld[s]) r_res[s] <= (s == 6) ? n6_res : r_res[(s == 6) ? 6 : s - 1];
    end

    logic [Q_W-1:0] quo;
    pif_div u_div (
        .i_clk (i_clk),
        .i_ld  (ld[DIV0+Q_W-1:DIV0]),
        .i_num (r4_num),
        .i_den (r4_den),
        .o_quo (quo)
    );

    // result
    assign o_out_valid    = r_v[NST];
    assign o_alive        = r_res[NST].alive;
    assign o_new_pos_x    = r_res[NST].pos[0];
    assign o_new_pos_y    = r_res[NST].pos[1];
    assign o_new_pos_z    = r_res[NST].pos[2];
    assign o_new_vel_x    = r_res[NST].vel[0];
    assign o_new_vel_y    = r_res[NST].vel[1];
    assign o_new_vel_z    = r_res[NST].vel[2];
    assign o_new_age      = r_res[NST].age;
    assign o_render_color = r_res[NST].alive ? {quo, r_res[NST].color[23:0]} : '0;
    assign o_visible      = r_res[NST].alive && (quo != '0);

endmodule
